[hdl/assert_macros.svh]
// assertion macros shared by the fir filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fir assertion failed");

`endif

[hdl/fir_pkg.sv]
// package with widths, register codes, types and rounding for the fir filter
package fir_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int ACC_W         = 40;
  localparam int FRAC_W        = 15;
  localparam int TAP_W         = 4;
  localparam int NUM_COEF      = 16;
  localparam int COEFS_PER_REG = 4;
  localparam int LANE_W        = 2;
  localparam int BANK_W        = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_TAPS_DEF  = 16;

  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd4;

  typedef struct packed {
    logic clear;      // start of a new sum
    logic load;       // sample and coefficient valid this cycle
    logic tap_live;   // delay line entry has been written since reset
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;       // product waiting to be accumulated
  } mac_stat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clip;
  } round_t;

  // round half up to q1.15 and saturate
  function automatic round_t fir_round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] biased;
    logic signed [ACC_W:0] shifted;
    round_t                r;
    biased  = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(ROUND_BIAS));
    shifted = biased >>> FRAC_W;
    if (shifted > $signed((ACC_W + 1)'(OUT_MAX))) begin
      r.value = SAMPLE_W'(OUT_MAX);
      r.clip  = 1'b1;
    end else if (shifted < $signed((ACC_W + 1)'(OUT_MIN))) begin
      r.value = SAMPLE_W'(OUT_MIN);
      r.clip  = 1'b1;
    end else begin
      r.value = shifted[SAMPLE_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/fir_ram.sv]
// generic single write port ram with registered read
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/fir_mac.sv]
// shared multiply-accumulate unit, one tap per cycle
module fir_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fir_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]   sample,
  input  logic signed [fir_pkg::COEF_W-1:0]     coef,
  output fir_pkg::mac_stat_t                    stat,
  output logic signed [fir_pkg::ACC_W-1:0]      acc
);
  import fir_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.load;
    end
  end

  // product stage, unwritten entries count as zero
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.tap_live) begin
        prod <= sample * coef;
      end else begin
        prod <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign stat.busy = prod_vld;

endmodule

[hdl/fir_filter_variable_order.sv]
// top level: direct-form fir filter with one shared mac and a tap sequencer
// a sample is accepted only in the idle state, so a new sample waits until the previous result
// has been loaded into the output register; one mac per tap
// reset: synchronous, clears order, coefficients, sequencer and delay line fill
// the delay line ram itself is not cleared; a fill count masks unwritten taps
`include "assert_macros.svh"

module fir_filter_variable_order #(
  parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fir_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample_in,
  // filtered output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fir_pkg::SAMPLE_W-1:0]  filtered_out,
  output logic                                 clipped
);
  import fir_pkg::*;

  localparam int PW       = $clog2(MAX_TAPS);
  localparam int CW       = ((PW > TAP_W) ? PW : TAP_W) + 1;
  localparam int LAST_IDX = MAX_TAPS - 1;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  // configuration
  logic [TAP_W-1:0]         filter_order;
  logic [COEF_W-1:0]        coef [NUM_COEF];
  logic [BANK_W-1:0]        cfg_bank;

  // sequencer and delay line control
  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [TAP_W-1:0]         tap;
  logic [TAP_W-1:0]         last_tap;
  logic [PW-1:0]            ptr;
  logic [PW-1:0]            ptr_next;
  logic [PW:0]              fill;
  logic [CW-1:0]            addr_wide;
  logic [PW-1:0]            raddr;
  logic                     rd_vld;
  logic signed [COEF_W-1:0] coef_rd;
  logic                     live_rd;
  logic                     in_xact;
  logic                     out_load;

  // datapath
  logic [SAMPLE_W-1:0]        ram_rdata;
  mac_ctrl_t                  mac_ctrl;
  mac_stat_t                  mac_stat;
  logic signed [ACC_W-1:0]    acc;
  round_t                     res;

  assign cfg_bank = BANK_W'(cfg_index - REG_COEF_FIRST);

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_ORDER) begin
        filter_order <= cfg_data[TAP_W-1:0];
      end else if (cfg_index >= REG_COEF_FIRST && cfg_index <= REG_COEF_LAST) begin
        for (int j = 0; j < COEFS_PER_REG; j++) begin
          coef[{cfg_bank, LANE_W'(j)}] <= cfg_data[j*COEF_W +: COEF_W];
        end
      end
    end
  end

  // order clamped to the length of the delay line
  always_comb begin
    if (CW'(filter_order) > CW'(LAST_IDX)) begin
      last_tap = TAP_W'(LAST_IDX);
    end else begin
      last_tap = filter_order;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_xact  = in_valid && in_ready;

  // result goes out once the mac pipe is empty and the output register is free
  assign out_load = (state == S_DRAIN) && !rd_vld && !mac_stat.busy
                    && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xact) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (tap == last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tap counter walks 0..last_tap (the clamped order), one tap per cycle
  always_ff @(posedge clk) begin
    if (in_xact) begin
      tap <= '0;
    end else if (state == S_RUN) begin
      tap <= tap + 1'b1;
    end
  end

  // delay line as a circular buffer: newest sample sits at ptr
  assign ptr_next = (ptr == PW'(LAST_IDX)) ? '0 : ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (in_xact) begin
      ptr <= ptr_next;
      if (fill != (PW + 1)'(MAX_TAPS)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // tap k lives k places behind the newest sample, wrapping at the depth
  always_comb begin
    if (CW'(ptr) < CW'(tap)) begin
      addr_wide = CW'(ptr) + CW'(MAX_TAPS) - CW'(tap);
    end else begin
      addr_wide = CW'(ptr) - CW'(tap);
    end
  end

  assign raddr = addr_wide[PW-1:0];

  fir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_delay (
    .clk   (clk),
    .we    (in_xact),
    .waddr (ptr_next),
    .wdata (sample_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // coefficient and fill mask travel alongside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      coef_rd <= coef[tap];
      live_rd <= CW'(tap) < CW'(fill);
    end
  end

  assign mac_ctrl.clear    = in_xact;
  assign mac_ctrl.load     = rd_vld;
  assign mac_ctrl.tap_live = live_rd;

  fir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample ($signed(ram_rdata)),
    .coef   (coef_rd),
    .stat   (mac_stat),
    .acc    (acc)
  );

  assign res = fir_round_sat(acc);

  // output register decouples the consumer from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_out <= res.value;
      clipped      <= res.clip;
    end
  end

  // a running sum always has at least the newest sample in the line
  `ASSERT_IMPL(a_fill_on_run, state == S_RUN, fill != '0)
  // the mac pipe is empty whenever a new sample may enter
  `ASSERT_IMPL(a_idle_drained, state == S_IDLE, !rd_vld && !mac_stat.busy)
  // a fresh result only ever comes from the drain state
  `ASSERT_IMPL(a_result_source, $rose(out_valid), $past(state) == S_DRAIN)
  // write pointer stays inside the delay line
  `ASSERT_IMPL(a_ptr_range, 1'b1, ptr <= PW'(LAST_IDX))

endmodule
